>>> sv/svr_pkg.sv
// Shared types and constants for the submesh vertex renumbering block.
// Holds the payload structs, the map entry layout and the memory request bundle.
// No dependencies; every other file of the block refers to it by scoped names.
package svr_pkg;

  // Map geometry: one entry per original vertex index.
  localparam int unsigned MAP_AW = 16;
  localparam int unsigned NUM_W  = 16;
  localparam int unsigned TAG_W  = 8;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned LIM_W  = 25;

  // Largest count of compact numbers handed out after one start.
  localparam int unsigned VERTICES = 65536;

  // Number reported for a corner that could not be numbered any more.
  localparam logic [NUM_W-1:0] NO_NUMBER = '1;

  // Command codes of an input beat.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_QUAD  = 1'b1;

  typedef struct packed {
    logic             command;
    logic [NUM_W-1:0] corner0;
    logic [NUM_W-1:0] corner1;
    logic [NUM_W-1:0] corner2;
    logic [NUM_W-1:0] corner3;
    logic [NUM_W-1:0] owner_id;
  } svr_in_t;

  typedef struct packed {
    logic             kept;
    logic [NUM_W-1:0] new_corner0;
    logic [NUM_W-1:0] new_corner1;
    logic [NUM_W-1:0] new_corner2;
    logic [NUM_W-1:0] new_corner3;
    logic [3:0]       fresh_mask;
    logic [CNT_W-1:0] vertex_total;
  } svr_out_t;

  // One map entry: the entry is valid when its tag matches the current epoch.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [NUM_W-1:0] number;
  } svr_entry_t;

  // Request bundle from the sequencer to the map memory.
  typedef struct packed {
    logic              rd_en;
    logic [MAP_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MAP_AW-1:0] wr_addr;
    svr_entry_t        wr_data;
  } svr_mem_req_t;

  // Picks one corner of a quad beat.
  function automatic logic [NUM_W-1:0] corner_of(svr_in_t item, logic [1:0] k);
    logic [NUM_W-1:0] c;
    unique case (k)
      2'd0:    c = item.corner0;
      2'd1:    c = item.corner1;
      2'd2:    c = item.corner2;
      default: c = item.corner3;
    endcase
    return c;
  endfunction

endpackage

>>> sv/svr_map_mem.sv
// Vertex map memory: one write port and one read port, read data registered.
// Depends on svr_pkg for the entry layout and the request bundle.
module svr_map_mem (
  input  logic                  clk,
  input  svr_pkg::svr_mem_req_t req,
  output svr_pkg::svr_entry_t   rd_data
);

  svr_pkg::svr_entry_t mem_r [2**svr_pkg::MAP_AW];
  svr_pkg::svr_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/svr_ctrl.sv
// Sequencer of the renumbering block: clearing pass, per-corner lookup and
// assignment, the vertex counter and the epoch that marks live map entries.
// Depends on svr_pkg; drives svr_map_mem through one request bundle.
module svr_ctrl #(
  parameter int unsigned VERTICES = svr_pkg::VERTICES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [svr_pkg::NUM_W-1:0]            target,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  svr_pkg::svr_in_t                     in_data,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output svr_pkg::svr_out_t                    res_data,
  output svr_pkg::svr_mem_req_t                mem_req,
  input  svr_pkg::svr_entry_t                  mem_rd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FINISH
  } state_t;

  state_t                         state_r, state_nxt;
  logic [svr_pkg::MAP_AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [svr_pkg::TAG_W-1:0]      epoch_r, epoch_nxt;
  logic [svr_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                           clear_pend_r, clear_pend_nxt;
  logic [2:0]                     step_r, step_nxt;
  logic                           kept_r, kept_nxt;
  logic [3:0]                     fresh_r, fresh_nxt;
  logic [svr_pkg::NUM_W-1:0]      num_r [4];
  logic [svr_pkg::NUM_W-1:0]      num_nxt [4];
  svr_pkg::svr_in_t               item_r, item_nxt;

  logic [1:0]                     rs_k;
  logic [svr_pkg::NUM_W-1:0]      rs_corner;
  logic                           fwd_hit;
  logic [svr_pkg::NUM_W-1:0]      fwd_num;
  logic                           full;

  assign rs_k      = 2'(step_r - 3'd1);
  assign rs_corner = svr_pkg::corner_of(item_r, rs_k);
  assign full      = svr_pkg::LIM_W'(count_r) >= svr_pkg::LIM_W'(VERTICES);

  // A corner repeated inside the quad takes the outcome of its first occurrence.
  always_comb begin
    fwd_hit = 1'b0;
    fwd_num = '0;
    for (int j = 0; j < 3; j++) begin
      if (!fwd_hit && 2'(j) < rs_k && svr_pkg::corner_of(item_r, 2'(j)) == rs_corner) begin
        fwd_hit = 1'b1;
        fwd_num = num_r[j];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    epoch_nxt      = epoch_r;
    count_nxt      = count_r;
    clear_pend_nxt = clear_pend_r;
    step_nxt       = step_r;
    kept_nxt       = kept_r;
    fresh_nxt      = fresh_r;
    num_nxt        = num_r;
    item_nxt       = item_r;
    mem_req        = '0;
    in_ready       = 1'b0;
    res_valid      = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_addr_r;
        mem_req.wr_data = '0;
        clr_addr_nxt    = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_data;
          kept_nxt  = 1'b0;
          fresh_nxt = '0;
          for (int k = 0; k < 4; k++) begin
            num_nxt[k] = '0;
          end
          if (in_data.command == svr_pkg::CMD_START) begin
            count_nxt = '0;
            state_nxt = ST_FINISH;
            // Tag zero marks cleared entries; running out of epochs forces a sweep.
            if (epoch_r == '1) begin
              epoch_nxt      = svr_pkg::TAG_W'(1);
              clear_pend_nxt = 1'b1;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
            end
          end else if (in_data.owner_id != target) begin
            state_nxt = ST_FINISH;
          end else begin
            kept_nxt  = 1'b1;
            step_nxt  = '0;
            state_nxt = ST_LOOKUP;
          end
        end
      end

      ST_LOOKUP: begin
        if (step_r < 3'd4) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = svr_pkg::corner_of(item_r, step_r[1:0]);
        end
        if (step_r != 3'd0) begin
          if (fwd_hit) begin
            num_nxt[rs_k] = fwd_num;
          end else if (mem_rd.tag == epoch_r) begin
            num_nxt[rs_k] = mem_rd.number;
          end else if (full) begin
            num_nxt[rs_k] = svr_pkg::NO_NUMBER;
          end else begin
            num_nxt[rs_k]          = count_r[svr_pkg::NUM_W-1:0];
            fresh_nxt[rs_k]        = 1'b1;
            count_nxt              = count_r + 1'b1;
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = rs_corner;
            mem_req.wr_data.tag    = epoch_r;
            mem_req.wr_data.number = count_r[svr_pkg::NUM_W-1:0];
          end
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 3'd4) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (clear_pend_r) begin
            clear_pend_nxt = 1'b0;
            clr_addr_nxt   = '0;
            state_nxt      = ST_CLEAR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res_data.kept         = kept_r;
    res_data.new_corner0  = num_r[0];
    res_data.new_corner1  = num_r[1];
    res_data.new_corner2  = num_r[2];
    res_data.new_corner3  = num_r[3];
    res_data.fresh_mask   = fresh_r;
    res_data.vertex_total = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      epoch_r      <= svr_pkg::TAG_W'(1);
      count_r      <= '0;
      clear_pend_r <= 1'b0;
      step_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      epoch_r      <= epoch_nxt;
      count_r      <= count_nxt;
      clear_pend_r <= clear_pend_nxt;
      step_r       <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    kept_r  <= kept_nxt;
    fresh_r <= fresh_nxt;
    num_r   <= num_nxt;
  end

endmodule

>>> sv/submesh_vertex_renumbering.sv
// Submesh vertex renumbering: top level with ports, configuration and output register.
// Depends on svr_pkg, svr_ctrl and svr_map_mem.
//
// This block takes a stream of quads and keeps those whose first-corner object id
// equals the configured target, giving each distinct original vertex a compact
// number in order of first use. A matching quad beat is kept, mismatched quads
// pass through with kept clear and the current total, and a start beat resets
// the numbering. The map sits in one 64K-entry memory with one read and one
// write port; its entries carry an epoch tag, so a start costs nothing, except
// that every 255th start runs a clearing sweep. After reset, and after such a
// start, the block sweeps the whole map and accepts no input beat meanwhile;
// configuration writes are always taken. A kept quad has its corners read one
// per cycle, each decided and written back in the cycle after its read, between
// acceptance and handoff. One item is worked on at a time, but a finished result
// waits in the output register, so the next beat can be accepted while it is
// still held.
module submesh_vertex_renumbering #(
  parameter int unsigned VERTICES = svr_pkg::VERTICES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  svr_pkg::svr_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output svr_pkg::svr_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [svr_pkg::NUM_W-1:0] cfg_data
);

  logic [svr_pkg::NUM_W-1:0] target_r;
  logic                      out_valid_r;
  svr_pkg::svr_out_t         out_data_r;

  logic                      res_valid;
  logic                      res_ready;
  svr_pkg::svr_out_t         res_data;
  svr_pkg::svr_mem_req_t     mem_req;
  svr_pkg::svr_entry_t       mem_rd;

  // The target register is written whenever a configuration beat arrives.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_valid) begin
      target_r <= cfg_data;
    end
  end

  // The output register frees up in the same cycle that its beat is taken.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  svr_ctrl #(
    .VERTICES (VERTICES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .target    (target_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .mem_rd    (mem_rd)
  );

  svr_map_mem u_map (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

endmodule

>>> test/submesh_vertex_renumbering_tb.sv
// Self-checking testbench for the submesh vertex renumbering block.
// Depends on svr_pkg and submesh_vertex_renumbering; needs no files or arguments.
// Directed quads and random phases are checked against a predictor.
`timescale 1ns / 1ps

module submesh_vertex_renumbering_tb;

  // The map sweep after reset moves no beat on the input side. The quiet-cycle
  // limit covers that sweep several times over.
  localparam int QUIET_LIMIT  = 300_000;
  // This covers the work on one kept quad, from acceptance to result.
  localparam int SETTLE_CYCLES = 12;

  // Predicts the result beat of every accepted input beat and holds the
  // expectations in order until the block delivers them.
  class renumber_scoreboard;
    logic [svr_pkg::NUM_W-1:0] target = '0;
    // Original vertex index to compact number, for vertices seen since the last start.
    bit [svr_pkg::NUM_W-1:0]   compact_of[bit [svr_pkg::NUM_W-1:0]];
    int unsigned               issued = 0;
    svr_pkg::svr_out_t         expected_results[$];
    int unsigned               mismatches = 0;

    function int pending();
      return expected_results.size();
    endfunction

    // Works out the result of one accepted input beat and queues it.
    function void record_item(svr_pkg::svr_in_t item);
      svr_pkg::svr_out_t         res;
      logic [svr_pkg::NUM_W-1:0] corner[4];
      logic [svr_pkg::NUM_W-1:0] number[4];
      res = '0;
      if (item.command == svr_pkg::CMD_START) begin
        compact_of.delete();
        issued = 0;
      end else if (item.owner_id != target) begin
        res.vertex_total = svr_pkg::CNT_W'(issued);
      end else begin
        corner[0] = item.corner0;
        corner[1] = item.corner1;
        corner[2] = item.corner2;
        corner[3] = item.corner3;
        // Corners are taken strictly in order, so a repeat inside the quad
        // finds the number that its earlier occurrence just received.
        for (int k = 0; k < 4; k++) begin
          if (compact_of.exists(corner[k])) begin
            number[k] = compact_of[corner[k]];
          end else if (issued >= svr_pkg::VERTICES) begin
            number[k] = svr_pkg::NO_NUMBER;
          end else begin
            compact_of[corner[k]] = svr_pkg::NUM_W'(issued);
            number[k] = svr_pkg::NUM_W'(issued);
            issued++;
            res.fresh_mask[k] = 1'b1;
          end
        end
        res.kept         = 1'b1;
        res.new_corner0  = number[0];
        res.new_corner1  = number[1];
        res.new_corner2  = number[2];
        res.new_corner3  = number[3];
        res.vertex_total = svr_pkg::CNT_W'(issued);
      end
      expected_results.push_back(res);
    endfunction

    // Compares one delivered result beat with the oldest expectation.
    function void check_beat(svr_pkg::svr_out_t got);
      svr_pkg::svr_out_t want;
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: result beat with nothing expected: %h", got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.kept !== want.kept || got.new_corner0 !== want.new_corner0 ||
          got.new_corner1 !== want.new_corner1 || got.new_corner2 !== want.new_corner2 ||
          got.new_corner3 !== want.new_corner3 || got.fresh_mask !== want.fresh_mask ||
          got.vertex_total !== want.vertex_total) begin
        if (mismatches < 10) begin
          $display("ERROR: expected kept=%b corners=%h %h %h %h fresh=%b total=%0d",
                   want.kept, want.new_corner0, want.new_corner1, want.new_corner2,
                   want.new_corner3, want.fresh_mask, want.vertex_total);
          $display("       got      kept=%b corners=%h %h %h %h fresh=%b total=%0d",
                   got.kept, got.new_corner0, got.new_corner1, got.new_corner2,
                   got.new_corner3, got.fresh_mask, got.vertex_total);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  svr_pkg::svr_in_t          in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  svr_pkg::svr_out_t         out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [svr_pkg::NUM_W-1:0] cfg_data = '0;

  renumber_scoreboard sb = new;

  // When clear, neither side inserts gaps; the output side reads this too.
  bit idling_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  submesh_vertex_renumbering DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: every beat taken is checked, then out_ready for the next
  // cycle is chosen.
  always @(posedge clk) begin
    if (out_valid && out_ready)
      sb.check_beat(out_data);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: counts cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one input beat and returns at the edge where it is taken. Valid is
  // left high, so back-to-back beats keep it high without a dip; a gap lowers
  // it first.
  task automatic send_beat(input svr_pkg::svr_in_t item);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.record_item(item);
  endtask

  // Holds the sender back until every expected result has come out, then lets
  // the block finish any work still under way.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input logic [svr_pkg::NUM_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.target = value;
  endtask

  function automatic svr_pkg::svr_in_t quad(input logic [svr_pkg::NUM_W-1:0] c0,
                                            input logic [svr_pkg::NUM_W-1:0] c1,
                                            input logic [svr_pkg::NUM_W-1:0] c2,
                                            input logic [svr_pkg::NUM_W-1:0] c3,
                                            input logic [svr_pkg::NUM_W-1:0] owner);
    svr_pkg::svr_in_t it;
    it.command  = svr_pkg::CMD_QUAD;
    it.corner0  = c0;
    it.corner1  = c1;
    it.corner2  = c2;
    it.corner3  = c3;
    it.owner_id = owner;
    return it;
  endfunction

  // A start beat carries random corner and owner fields, which the block ignores.
  function automatic svr_pkg::svr_in_t start_beat();
    svr_pkg::svr_in_t it;
    it = quad(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    it.command = svr_pkg::CMD_START;
    return it;
  endfunction

  // A random quad. Most corners come from a small window of vertex indices so
  // that vertices recur across quads; some repeat an earlier corner of the
  // same quad, some are extremes or fully random. Most quads belong to the
  // target, a few miss it by one bit, the rest carry a random owner.
  function automatic svr_pkg::svr_in_t random_quad(input logic [svr_pkg::NUM_W-1:0] target,
                                                   input logic [svr_pkg::NUM_W-1:0] window);
    logic [svr_pkg::NUM_W-1:0] c[4];
    logic [svr_pkg::NUM_W-1:0] owner;
    int                        pick;
    for (int k = 0; k < 4; k++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0)
        c[k] = '0;
      else if (pick == 1)
        c[k] = '1;
      else if (pick <= 3)
        c[k] = 16'($urandom);
      else if (pick <= 6 && k > 0)
        c[k] = c[$urandom_range(0, k - 1)];
      else
        c[k] = window + 16'($urandom_range(0, 47));
    end
    pick = $urandom_range(0, 9);
    if (pick < 7)
      owner = target;
    else if (pick == 7)
      owner = target ^ (16'h1 << $urandom_range(0, 15));
    else
      owner = 16'($urandom);
    return quad(c[0], c[1], c[2], c[3], owner);
  endfunction

  initial begin
    logic [svr_pkg::NUM_W-1:0] target;
    logic [svr_pkg::NUM_W-1:0] window;
    int                        count;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // The register takes writes even during the sweep after reset.
    write_target(16'h0000);

    // Directed part: index extremes, repeats inside a quad, other objects,
    // a start with junk fields, and the map surviving a target change.
    send_beat(quad(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    send_beat(quad(16'h0009, 16'h0009, 16'h0009, 16'h0009, 16'h0000));
    send_beat(quad(16'hFFFF, 16'h0009, 16'h0000, 16'h0003, 16'h0000));
    send_beat(quad(16'h0100, 16'h0101, 16'h0102, 16'h0103, 16'h0001));
    send_beat(quad(16'h0100, 16'h0101, 16'h0102, 16'h0103, 16'hFFFF));
    send_beat(start_beat());
    send_beat(quad(16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0000));
    send_beat(quad(16'h0004, 16'h0003, 16'h0002, 16'h0001, 16'h0000));
    send_beat(quad(16'h0001, 16'h0001, 16'h0005, 16'h0005, 16'h0000));
    drain_results();
    write_target(16'hFFFF);
    send_beat(quad(16'h0005, 16'h0006, 16'h0006, 16'hFFFF, 16'hFFFF));
    send_beat(quad(16'h0007, 16'h0008, 16'h0009, 16'h000A, 16'h0000));
    send_beat(quad(16'h0007, 16'h0008, 16'h0009, 16'h000A, 16'h7FFF));
    send_beat(start_beat());
    send_beat(quad(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hFFFF));
    send_beat(quad(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 16'hFFFF));

    // Random phases. Each begins with the block drained, a new target and a
    // start. The third phase runs without gaps, and so does the last.
    for (int phase = 0; phase < 7; phase++) begin
      drain_results();
      if (phase == 1)
        target = 16'hFFFF;
      else if (phase == 3)
        target = 16'h0000;
      else
        target = 16'($urandom);
      write_target(target);
      idling_on = (phase != 2 && phase != 6);
      window = 16'($urandom);
      send_beat(start_beat());
      count = (phase == 6) ? 85 : 58;
      for (int n = 0; n < count; n++) begin
        if ($urandom_range(0, 24) == 0)
          send_beat(start_beat());
        else
          send_beat(random_quad(target, window));
        // Now and then the sender waits for the block to empty completely.
        if (phase != 6 && $urandom_range(0, 59) == 0)
          drain_results();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
